// File: design/priority_voice_allocator_macros.svh
// ----------------------------------------------------------------------------
// priority_voice_allocator_macros.svh
// Assertion macros for the voice allocator; empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_VOICE_ALLOCATOR_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PVA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pva assertion failed");

// next-cycle implication
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pva assertion failed");

`else

`define PVA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the priority voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int CMD_W  = 2;
  localparam int PRIO_W = 8;
  localparam int WORD_W = 32;
  localparam int TGT_W  = 5;
  localparam int CH_W   = 5;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACTIVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [PRIO_W-1:0] PROTECTED_PRIO = 8'h7F;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_ACTIVE = 2'd1,
    ST_STOLEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_RESP
  } state_t;

  // per-slot record held in RAM
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [WORD_W-1:0] age;
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] handler;
  } slot_rec_t;

  typedef struct packed {
    logic              granted;
    logic [CH_W-1:0]   channel;
    logic              evict_notify;
    logic [WORD_W-1:0] evicted_tag;
    logic [WORD_W-1:0] evicted_handler;
  } result_t;

endpackage

`default_nettype wire

// File: design/pva_in_if.sv
// ----------------------------------------------------------------------------
// pva_in_if
// Request channel: command item with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_in_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::CMD_W-1:0]   cmd;
  logic [pva_pkg::PRIO_W-1:0]  priority_req;
  logic [pva_pkg::WORD_W-1:0]  owner_tag;
  logic [pva_pkg::WORD_W-1:0]  handler_id;
  logic [pva_pkg::WORD_W-1:0]  seq_stamp;
  logic [pva_pkg::TGT_W-1:0]   target_slot;

  modport source (
    output valid, cmd, priority_req, owner_tag, handler_id, seq_stamp, target_slot,
    input  ready
  );
  modport sink (
    input  valid, cmd, priority_req, owner_tag, handler_id, seq_stamp, target_slot,
    output ready
  );
endinterface

`default_nettype wire

// File: design/pva_out_if.sv
// ----------------------------------------------------------------------------
// pva_out_if
// Result channel: grant / eviction item with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_out_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [pva_pkg::CH_W-1:0]    channel;
  logic                        evict_notify;
  logic [pva_pkg::WORD_W-1:0]  evicted_tag;
  logic [pva_pkg::WORD_W-1:0]  evicted_handler;

  modport source (
    output valid, granted, channel, evict_notify, evicted_tag, evicted_handler,
    input  ready
  );
  modport sink (
    input  valid, granted, channel, evict_notify, evicted_tag, evicted_handler,
    output ready
  );
endinterface

`default_nettype wire

// File: design/pva_ram.sv
// ----------------------------------------------------------------------------
// pva_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/priority_voice_allocator.sv
// ----------------------------------------------------------------------------
// priority_voice_allocator
// Grants one of NUM_SLOTS sound channels; steals the lowest-priority, oldest
// slot when none is free. Allocate takes the lowest free slot; if none, the
// victim is the lowest priority, then smallest age stamp, then lowest index,
// and is refused if the request's priority is lower or the victim is
// protected (127). Slot records live in a RAM that is read one slot per
// cycle by a single compare unit; slot status lives in flip-flops cleared by
// reset. Mark-active and release skip the scan; an allocate scans from
// slot 0 and stops at the first free slot, while a steal or refusal is
// decided after a full scan of all slots, then a drain and a decide step.
// One item at a time; a finished result waits in the output register
// while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_voice_allocator_macros.svh"

module priority_voice_allocator #(
  parameter int NUM_SLOTS = 24
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pva_in_if.sink     in_ch,
  pva_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam int REC_W = $bits(pva_pkg::slot_rec_t);

  pva_pkg::state_t state_r, state_nxt;
  pva_pkg::status_t status_r [NUM_SLOTS];
  pva_pkg::status_t status_nxt [NUM_SLOTS];

  // latched request
  logic [pva_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [pva_pkg::WORD_W-1:0] stamp_r, stamp_nxt;
  logic [pva_pkg::WORD_W-1:0] tag_r, tag_nxt;
  logic [pva_pkg::WORD_W-1:0] hnd_r, hnd_nxt;

  // scan sequencer
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  // running victim
  logic [pva_pkg::PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [pva_pkg::WORD_W-1:0] best_age_r, best_age_nxt;
  logic [pva_pkg::WORD_W-1:0] best_tag_r, best_tag_nxt;
  logic [pva_pkg::WORD_W-1:0] best_hnd_r, best_hnd_nxt;
  logic [IDX_W-1:0]           best_idx_r, best_idx_nxt;

  pva_pkg::result_t res_r, res_nxt;
  pva_pkg::result_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // RAM port
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  pva_pkg::slot_rec_t  ram_wrec;
  pva_pkg::slot_rec_t  ram_rrec;
  logic [REC_W-1:0]    ram_rdata;

  logic in_fire;
  logic out_load;
  logic free_hit;
  logic tgt_ok;
  logic take_new;
  logic refuse;

  assign in_ch.ready = (state_r == pva_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == pva_pkg::S_RESP) && (!out_valid_r || out_ch.ready);
  assign free_hit    = (status_r[idx_r] == pva_pkg::ST_FREE);
  assign tgt_ok      = (32'(in_ch.target_slot) < 32'(NUM_SLOTS));
  assign ram_rrec    = pva_pkg::slot_rec_t'(ram_rdata);

  assign take_new = (rd_idx_r == '0) || (ram_rrec.prio < best_prio_r) ||
                    ((ram_rrec.prio == best_prio_r) && (ram_rrec.age < best_age_r));
  assign refuse   = (prio_r < best_prio_r) || (best_prio_r == pva_pkg::PROTECTED_PRIO);

  assign ram_wrec.prio    = prio_r;
  assign ram_wrec.age     = stamp_r;
  assign ram_wrec.tag     = tag_r;
  assign ram_wrec.handler = hnd_r;

  pva_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pva_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.cmd == pva_pkg::CMD_ALLOC) ? pva_pkg::S_SCAN : pva_pkg::S_RESP;
        end
      end
      pva_pkg::S_SCAN: begin
        if (free_hit) begin
          state_nxt = pva_pkg::S_RESP;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = pva_pkg::S_DRAIN;
        end
      end
      pva_pkg::S_DRAIN:  state_nxt = pva_pkg::S_DECIDE;
      pva_pkg::S_DECIDE: state_nxt = pva_pkg::S_RESP;
      pva_pkg::S_RESP: begin
        if (out_load) begin
          state_nxt = pva_pkg::S_IDLE;
        end
      end
      default: state_nxt = pva_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    status_nxt    = status_r;
    prio_nxt      = prio_r;
    stamp_nxt     = stamp_r;
    tag_nxt       = tag_r;
    hnd_nxt       = hnd_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = idx_r;
    rd_vld_nxt    = 1'b0;
    best_prio_nxt = best_prio_r;
    best_age_nxt  = best_age_r;
    best_tag_nxt  = best_tag_r;
    best_hnd_nxt  = best_hnd_r;
    best_idx_nxt  = best_idx_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;

    // victim compare on data read the previous cycle
    if (rd_vld_r && take_new) begin
      best_prio_nxt = ram_rrec.prio;
      best_age_nxt  = ram_rrec.age;
      best_tag_nxt  = ram_rrec.tag;
      best_hnd_nxt  = ram_rrec.handler;
      best_idx_nxt  = rd_idx_r;
    end

    case (state_r)
      pva_pkg::S_IDLE: begin
        if (in_fire) begin
          prio_nxt  = in_ch.priority_req;
          stamp_nxt = in_ch.seq_stamp;
          tag_nxt   = in_ch.owner_tag;
          hnd_nxt   = in_ch.handler_id;
          idx_nxt   = '0;
          res_nxt   = '0;
          if (((in_ch.cmd == pva_pkg::CMD_ACTIVE) || (in_ch.cmd == pva_pkg::CMD_RELEASE)) &&
              tgt_ok) begin
            status_nxt[IDX_W'(in_ch.target_slot)] =
              (in_ch.cmd == pva_pkg::CMD_ACTIVE) ? pva_pkg::ST_ACTIVE : pva_pkg::ST_FREE;
            res_nxt.granted = 1'b1;
            res_nxt.channel = in_ch.target_slot;
          end
        end
      end
      pva_pkg::S_SCAN: begin
        if (free_hit) begin
          // free slot keeps status free; only the record is written
          ram_we          = 1'b1;
          ram_waddr       = idx_r;
          res_nxt.granted = 1'b1;
          res_nxt.channel = pva_pkg::CH_W'(idx_r);
        end else begin
          rd_vld_nxt = 1'b1;
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      pva_pkg::S_DECIDE: begin
        if (!refuse) begin
          ram_we                  = 1'b1;
          ram_waddr               = best_idx_r;
          status_nxt[best_idx_r]  = pva_pkg::ST_STOLEN;
          res_nxt.granted         = 1'b1;
          res_nxt.channel         = pva_pkg::CH_W'(best_idx_r);
          res_nxt.evict_notify    = (best_hnd_r != '0);
          res_nxt.evicted_tag     = best_tag_r;
          res_nxt.evicted_handler = best_hnd_r;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pva_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      idx_r       <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_r[i] <= pva_pkg::ST_FREE;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      idx_r       <= idx_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r      <= prio_nxt;
    stamp_r     <= stamp_nxt;
    tag_r       <= tag_nxt;
    hnd_r       <= hnd_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_age_r  <= best_age_nxt;
    best_tag_r  <= best_tag_nxt;
    best_hnd_r  <= best_hnd_nxt;
    best_idx_r  <= best_idx_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.granted         = out_r.granted;
  assign out_ch.channel         = out_r.channel;
  assign out_ch.evict_notify    = out_r.evict_notify;
  assign out_ch.evicted_tag     = out_r.evicted_tag;
  assign out_ch.evicted_handler = out_r.evicted_handler;

  `PVA_ASSERT_IMPL(a_notify_has_handler, clk, rst_n, out_valid_r && out_r.evict_notify, out_r.evicted_handler != '0)
  `PVA_ASSERT_IMPL(a_refused_clean, clk, rst_n, out_valid_r && !out_r.granted, (out_r.channel == '0) && !out_r.evict_notify)
  `PVA_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_r == pva_pkg::S_SCAN, idx_r <= LAST_IDX)
  `PVA_ASSERT_NEXT(a_decide_to_resp, clk, rst_n, state_r == pva_pkg::S_DECIDE, state_r == pva_pkg::S_RESP)

endmodule

`default_nettype wire

// File: dv/priority_voice_allocator_test.sv
// ----------------------------------------------------------------------------
// priority_voice_allocator_test
// Self-checking bench for the voice allocator. A short table of directed
// items covers free grants, protected and lower-priority refusals, steals
// with and without a handler, age and index tie-breaks and ignored commands.
// Random items follow: mostly allocates and mark-actives, with some
// releases and noise. Each result item is checked against a local model of
// the slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_voice_allocator_test;

  localparam int NUM_SLOTS      = 24;
  localparam int RAND_ITEMS     = 1800;
  localparam int HOLD_AT        = 500;
  localparam int DRAIN_AT       = 1200;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 64;

  localparam logic [pva_pkg::CMD_W-1:0] CMD_UNDEF = 2'd3;

  typedef struct packed {
    logic [pva_pkg::CMD_W-1:0]  cmd;
    logic [pva_pkg::PRIO_W-1:0] prio;
    logic [pva_pkg::WORD_W-1:0] tag;
    logic [pva_pkg::WORD_W-1:0] hnd;
    logic [pva_pkg::WORD_W-1:0] stamp;
    logic [pva_pkg::TGT_W-1:0]  tgt;
  } voice_req_t;

  typedef enum logic {ROW_ITEM, ROW_FILL} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    voice_req_t       req;
    bit               has_lit;
    pva_pkg::result_t lit;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BEAT} rx_mode_t;

  logic clk;
  logic rst_n;

  pva_in_if  in_ch();
  pva_out_if out_ch();

  priority_voice_allocator #(.NUM_SLOTS(NUM_SLOTS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the slot table
  pva_pkg::status_t           slot_state   [NUM_SLOTS];
  logic [pva_pkg::PRIO_W-1:0] slot_prio    [NUM_SLOTS];
  logic [pva_pkg::WORD_W-1:0] slot_age     [NUM_SLOTS];
  logic [pva_pkg::WORD_W-1:0] slot_tag     [NUM_SLOTS];
  logic [pva_pkg::WORD_W-1:0] slot_hnd     [NUM_SLOTS];
  bit                         slot_written [NUM_SLOTS];

  pva_pkg::result_t grant_q[$];
  pva_pkg::result_t last_grant;
  stim_row_t        stim_rows[$];
  int               errors;
  int               burst_left;
  bit               stim_done;
  bit               rx_hold_req;
  int               idle_cycles;
  rx_mode_t         rx_mode;
  int               rx_left;
  int               rx_phase;
  pva_pkg::result_t head_res;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void store_voice(input int s, input voice_req_t r);
    slot_prio[s]    = r.prio;
    slot_tag[s]     = r.tag;
    slot_hnd[s]     = r.hnd;
    slot_age[s]     = r.stamp;
    slot_written[s] = 1'b1;
  endfunction

  // expected grant for one request; updates the slot table
  function automatic pva_pkg::result_t voice_grant(input voice_req_t r);
    pva_pkg::result_t res;
    int               victim;
    res    = '0;
    victim = 0;
    if (r.cmd == pva_pkg::CMD_ALLOC) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_state[i] == pva_pkg::ST_FREE) begin
          store_voice(i, r);
          res.granted = 1'b1;
          res.channel = pva_pkg::CH_W'(i);
          return res;
        end
      end
      // lowest priority, then oldest stamp, then lowest index
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (slot_prio[i] < slot_prio[victim] ||
            (slot_prio[i] == slot_prio[victim] && slot_age[i] < slot_age[victim]))
          victim = i;
      end
      if (r.prio < slot_prio[victim] || slot_prio[victim] == pva_pkg::PROTECTED_PRIO)
        return res;
      res.granted         = 1'b1;
      res.channel         = pva_pkg::CH_W'(victim);
      res.evict_notify    = (slot_hnd[victim] != '0);
      res.evicted_tag     = slot_tag[victim];
      res.evicted_handler = slot_hnd[victim];
      slot_state[victim]  = pva_pkg::ST_STOLEN;
      store_voice(victim, r);
    end else if ((r.cmd == pva_pkg::CMD_ACTIVE || r.cmd == pva_pkg::CMD_RELEASE) &&
                 r.tgt < NUM_SLOTS) begin
      slot_state[r.tgt] = (r.cmd == pva_pkg::CMD_ACTIVE) ? pva_pkg::ST_ACTIVE
                                                         : pva_pkg::ST_FREE;
      res.granted = 1'b1;
      res.channel = r.tgt;
    end
    return res;
  endfunction

  // mark-active only ever hits slots that already hold a record, so the
  // victim search never sees unwritten priority or age
  function automatic voice_req_t random_req();
    voice_req_t r;
    int         pick;
    int         sel;
    int         free_wr[$];
    int         wr[$];
    r.cmd   = pva_pkg::CMD_ALLOC;
    r.prio  = pva_pkg::PRIO_W'($urandom);
    r.tag   = $urandom;
    r.hnd   = $urandom;
    r.stamp = $urandom;
    r.tgt   = pva_pkg::TGT_W'($urandom_range(0, 31));
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_written[i]) begin
        wr.push_back(i);
        if (slot_state[i] == pva_pkg::ST_FREE) free_wr.push_back(i);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 80 && wr.size() != 0) begin
      r.cmd = pva_pkg::CMD_ACTIVE;
      if (free_wr.size() != 0)
        r.tgt = pva_pkg::TGT_W'(free_wr[$urandom_range(0, free_wr.size() - 1)]);
      else
        r.tgt = pva_pkg::TGT_W'(wr[$urandom_range(0, wr.size() - 1)]);
    end else if (pick >= 80 && pick < 88) begin
      r.cmd = pva_pkg::CMD_RELEASE;
      r.tgt = pva_pkg::TGT_W'($urandom_range(0, NUM_SLOTS - 1));
    end else if (pick >= 88 && pick < 94) begin
      r.cmd = ($urandom_range(0, 1) != 0) ? pva_pkg::CMD_ACTIVE : pva_pkg::CMD_RELEASE;
      r.tgt = pva_pkg::TGT_W'($urandom_range(NUM_SLOTS, 31));
    end else if (pick >= 94) begin
      r.cmd = CMD_UNDEF;
    end else begin
      sel = $urandom_range(0, 9);
      if (sel == 0) r.prio = '0;
      else if (sel == 1) r.prio = '1;
      else if (sel == 2) r.prio = pva_pkg::PROTECTED_PRIO;
      else if (sel < 6) r.prio = pva_pkg::PRIO_W'($urandom_range(0, 6));
      sel = $urandom_range(0, 9);
      if (sel < 4) r.stamp = $urandom_range(0, 7);
      else if (sel == 4) r.stamp = '1;
      if ($urandom_range(0, 3) == 0) r.hnd = '0;
    end
    return r;
  endfunction

  function automatic void add_row(input row_kind_t k,
                                  input logic [pva_pkg::CMD_W-1:0] cmd,
                                  input logic [pva_pkg::PRIO_W-1:0] prio,
                                  input logic [pva_pkg::WORD_W-1:0] tag,
                                  input logic [pva_pkg::WORD_W-1:0] hnd,
                                  input logic [pva_pkg::WORD_W-1:0] stamp,
                                  input logic [pva_pkg::TGT_W-1:0] tgt,
                                  input bit has_lit, input pva_pkg::result_t lit);
    stim_row_t row;
    row.kind    = k;
    row.req     = '{cmd, prio, tag, hnd, stamp, tgt};
    row.has_lit = has_lit;
    row.lit     = lit;
    stim_rows.push_back(row);
  endfunction

  task automatic send_item(input voice_req_t r, input bit has_lit,
                           input pva_pkg::result_t lit);
    int               gap;
    pva_pkg::result_t exp_res;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= r.cmd;
    in_ch.priority_req <= r.prio;
    in_ch.owner_tag    <= r.tag;
    in_ch.handler_id   <= r.hnd;
    in_ch.seq_stamp    <= r.stamp;
    in_ch.target_slot  <= r.tgt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    exp_res = voice_grant(r);
    last_grant = exp_res;
    if (has_lit) exp_res = lit;
    grant_q.push_back(exp_res);
  endtask

  task automatic check_field(input string name, input logic [pva_pkg::WORD_W-1:0] exp_v,
                             input logic [pva_pkg::WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // stimulus
  initial begin
    voice_req_t req;
    stim_row_t  row;
    int         free_cnt;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = pva_pkg::CMD_ALLOC;
    in_ch.priority_req = '0;
    in_ch.owner_tag    = '0;
    in_ch.handler_id   = '0;
    in_ch.seq_stamp    = '0;
    in_ch.target_slot  = '0;
    errors      = 0;
    burst_left  = 0;
    stim_done   = 1'b0;
    rx_hold_req = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_state[i]   = pva_pkg::ST_FREE;
      slot_prio[i]    = '0;
      slot_age[i]     = '0;
      slot_tag[i]     = '0;
      slot_hnd[i]     = '0;
      slot_written[i] = 1'b0;
    end

    // ignored commands, free grants, reuse of an unmarked slot
    add_row(ROW_ITEM, pva_pkg::CMD_ACTIVE,  8'h00, '0, '0, '0, 5'd24, 1'b1, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_RELEASE, 8'h00, '0, '0, '0, 5'd31, 1'b1, '0);
    add_row(ROW_ITEM, CMD_UNDEF,            8'hFF, '0, '0, '0, 5'd5,  1'b1, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'hFF, '1, '1, '1, 5'd31, 1'b1,
            pva_pkg::result_t'{1'b1, 5'd0, 1'b0, 32'h0, 32'h0});
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'h00, '0, '0, '0, 5'd0,  1'b1,
            pva_pkg::result_t'{1'b1, 5'd0, 1'b0, 32'h0, 32'h0});
    add_row(ROW_ITEM, pva_pkg::CMD_ACTIVE,  8'h00, '0, '0, '0, 5'd0,  1'b1,
            pva_pkg::result_t'{1'b1, 5'd0, 1'b0, 32'h0, 32'h0});
    add_row(ROW_ITEM, pva_pkg::CMD_RELEASE, 8'h00, '0, '0, '0, 5'd0,  1'b1,
            pva_pkg::result_t'{1'b1, 5'd0, 1'b0, 32'h0, 32'h0});
    // every slot taken by protected voices: steal refused
    add_row(ROW_FILL, pva_pkg::CMD_ALLOC, pva_pkg::PROTECTED_PRIO, '0, '0, 32'd1000, '0,
            1'b0, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'hFF, '1, '1, 32'd1, 5'd0, 1'b1, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_RELEASE, 8'h00, '0, '0, '0, 5'd23, 1'b1,
            pva_pkg::result_t'{1'b1, 5'd23, 1'b0, 32'h0, 32'h0});
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd5, 32'hA5A5A5A5, 32'h0, 32'd100, 5'd0, 1'b1,
            pva_pkg::result_t'{1'b1, 5'd23, 1'b0, 32'h0, 32'h0});
    add_row(ROW_ITEM, pva_pkg::CMD_ACTIVE,  8'h00, '0, '0, '0, 5'd23, 1'b1,
            pva_pkg::result_t'{1'b1, 5'd23, 1'b0, 32'h0, 32'h0});
    // lower priority than the victim: refused
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd4, 32'h1, 32'h1, 32'd1, 5'd0, 1'b1, '0);
    // equal priority steals; victim without handler
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd5, 32'h5A5A5A5A, 32'h12345678, 32'd50, 5'd0,
            1'b1, pva_pkg::result_t'{1'b1, 5'd23, 1'b0, 32'hA5A5A5A5, 32'h0});
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd6, 32'hC3C3C3C3, 32'h0, 32'd40, 5'd0, 1'b1,
            pva_pkg::result_t'{1'b1, 5'd23, 1'b1, 32'h5A5A5A5A, 32'h12345678});
    // same priority and stamp on slots 22 and 23: lower index loses
    add_row(ROW_ITEM, pva_pkg::CMD_RELEASE, 8'h00, '0, '0, '0, 5'd22, 1'b1,
            pva_pkg::result_t'{1'b1, 5'd22, 1'b0, 32'h0, 32'h0});
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd6, 32'h11111111, 32'h22222222, 32'd40, 5'd0,
            1'b0, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ACTIVE,  8'h00, '0, '0, '0, 5'd22, 1'b0, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd200, 32'h33333333, 32'h44444444, 32'd7, 5'd0,
            1'b0, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd6, 32'h55555555, '1, 32'd41, 5'd0, 1'b0, '0);
    // same priority, higher index but older stamp loses
    add_row(ROW_ITEM, pva_pkg::CMD_RELEASE, 8'h00, '0, '0, '0, 5'd20, 1'b0, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'd6, 32'h66666666, 32'h77777777, '1, 5'd0,
            1'b0, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ACTIVE,  8'h00, '0, '0, '0, 5'd20, 1'b0, '0);
    add_row(ROW_ITEM, pva_pkg::CMD_ALLOC,   8'hFF, 32'h88888888, 32'h99999999, 32'd9, 5'd0,
            1'b0, '0);
    add_row(ROW_ITEM, CMD_UNDEF,            8'hFF, '1, '1, '1, 5'd31, 1'b1, '0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      if (row.kind == ROW_FILL) begin
        free_cnt = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_state[i] == pva_pkg::ST_FREE) free_cnt++;
        for (int n = 0; n < free_cnt; n++) begin
          req       = row.req;
          req.cmd   = pva_pkg::CMD_ALLOC;
          req.tag   = $urandom;
          req.hnd   = $urandom;
          req.stamp = row.req.stamp + pva_pkg::WORD_W'(n);
          send_item(req, 1'b0, '0);
          req.cmd = pva_pkg::CMD_ACTIVE;
          req.tgt = last_grant.channel;
          send_item(req, 1'b0, '0);
        end
      end else begin
        send_item(row.req, row.has_lit, row.lit);
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == HOLD_AT) rx_hold_req = 1'b1;
      if (n == DRAIN_AT) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (grant_q.size() != 0) @(posedge clk);
      end
      send_item(random_req(), 1'b0, '0);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: stall patterns, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    rx_mode  = RX_OPEN;
    rx_left  = 0;
    rx_phase = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
          RX_OPEN: begin
            out_ch.ready <= 1'b1;
          end
          RX_COIN: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ch.ready <= ((rx_phase % 5) < 2);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (grant_q.size() == 0) begin
        $error("result item with no request outstanding");
        errors++;
      end else begin
        head_res = grant_q.pop_front();
        check_field("granted", pva_pkg::WORD_W'(head_res.granted),
                    pva_pkg::WORD_W'(out_ch.granted));
        check_field("channel", pva_pkg::WORD_W'(head_res.channel),
                    pva_pkg::WORD_W'(out_ch.channel));
        check_field("evict_notify", pva_pkg::WORD_W'(head_res.evict_notify),
                    pva_pkg::WORD_W'(out_ch.evict_notify));
        check_field("evicted_tag",     head_res.evicted_tag,     out_ch.evicted_tag);
        check_field("evicted_handler", head_res.evicted_handler, out_ch.evicted_handler);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("no item moved for %0d cycles, %0d results outstanding",
           STALL_LIMIT, grant_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    wait (stim_done);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
